### hw/rtl/hop_eccentricity_from_start_defines.svh
// assertion macros for the hop eccentricity block
// expects clk_i and rst_ni in the scope of each use
`ifndef HOP_ECCENTRICITY_FROM_START_DEFINES_SVH
`define HOP_ECCENTRICITY_FROM_START_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HEF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HEF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hef_pkg.sv
// shared types and constants of the hop eccentricity block
// no dependencies
`default_nettype none

package hef_pkg;

  localparam int MaxVertices = 256;
  localparam int MaxEdges    = 1024;

  localparam int CntW  = 9;   // vertex_count register
  localparam int VtxW  = 8;   // vertex number
  localparam int EccW  = 9;   // eccentricity field
  localparam int DistW = 10;  // stored hop distance, holds count+2

  typedef struct packed {
    logic            edge_valid;
    logic [VtxW-1:0] edge_source;
    logic [VtxW-1:0] edge_target;
    logic            last_edge;
  } item_t;

  typedef struct packed {
    logic [EccW-1:0] eccentricity;
    logic            unreachable;
    logic            bad_start;
    logic            edges_dropped;
  } result_t;

  // run request from the load side to the relaxation engine
  typedef struct packed {
    logic            go;
    logic [CntW-1:0] count;
    logic [VtxW-1:0] start;
  } run_req_t;

  // completion report of the relaxation engine
  typedef struct packed {
    logic            done;
    logic [EccW-1:0] ecc;
    logic            unreach;
    logic            bad;
  } run_stat_t;

endpackage

`default_nettype wire

### hw/rtl/hef_ram.sv
// generic single-write, dual-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module hef_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0]  waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic                                      re_a_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0]  raddr_a_i,
  output logic      [Width-1:0]                          rdata_a_o,
  input  wire logic                                      re_b_i,
  input  wire logic [$clog2(Depth > 1 ? Depth : 2)-1:0]  raddr_b_i,
  output logic      [Width-1:0]                          rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hef_cfg_regs.sv
// apb register file: vertex_count at 0x0, start_vertex at 0x4
// depends on hef_pkg
`default_nettype none

module hef_cfg_regs (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel_i,
  input  wire logic                     penable_i,
  input  wire logic                     pwrite_i,
  input  wire logic [2:0]               paddr_i,
  input  wire logic [31:0]              pwdata_i,
  output logic      [31:0]              prdata_o,
  output logic                          pready_o,
  output logic      [hef_pkg::CntW-1:0] vertex_count_o,
  output logic      [hef_pkg::VtxW-1:0] start_vertex_o
);
  import hef_pkg::*;

  localparam logic RegVertexCount = 1'b0;
  localparam logic RegStartVertex = 1'b1;

  logic [CntW-1:0] vertex_count_q;
  logic [VtxW-1:0] start_vertex_q;
  logic            wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
      start_vertex_q <= '0;
    end else if (wr_en) begin
      unique case (paddr_i[2])
        RegVertexCount: vertex_count_q <= pwdata_i[CntW-1:0];
        RegStartVertex: start_vertex_q <= pwdata_i[VtxW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      RegVertexCount: prdata_o = 32'(vertex_count_q);
      RegStartVertex: prdata_o = 32'(start_vertex_q);
      default:        prdata_o = '0;
    endcase
  end

  assign vertex_count_o = vertex_count_q;
  assign start_vertex_o = start_vertex_q;

endmodule

`default_nettype wire

### hw/rtl/hef_relax.sv
// relaxation engine: distance init sweep, edge passes over the edge store,
// final max scan; holds the distance ram. depends on hef_pkg and hef_ram
`default_nettype none

module hef_relax #(
  parameter int MAX_VERTICES = hef_pkg::MaxVertices,
  parameter int MAX_EDGES    = hef_pkg::MaxEdges
) (
  input  wire logic                                             clk_i,
  input  wire logic                                             rst_ni,
  input  wire hef_pkg::run_req_t                                req_i,
  input  wire logic [$clog2(MAX_EDGES + 1)-1:0]                 edges_i,
  output logic                                                  edge_re_o,
  output logic      [$clog2(MAX_EDGES > 1 ? MAX_EDGES : 2)-1:0] edge_raddr_o,
  input  wire logic [2*hef_pkg::VtxW-1:0]                       edge_rdata_i,
  output hef_pkg::run_stat_t                                    stat_o
);
  import hef_pkg::*;

  localparam int DistDepth = (MAX_VERTICES < 512) ? MAX_VERTICES : 512;
  localparam int AW        = $clog2(DistDepth);
  localparam int EAW       = $clog2(MAX_EDGES > 1 ? MAX_EDGES : 2);
  localparam int LW        = $clog2(MAX_EDGES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_EREAD = 3'd2;
  localparam logic [2:0] S_EDGE  = 3'd3;
  localparam logic [2:0] S_RELAX = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  v_q, v_d, v_nx;
  logic [EAW-1:0]   e_q, e_d;
  logic [LW-1:0]    e_nx;
  logic [CntW-1:0]  pass_q, pass_d;
  logic [CntW:0]    pass_nx;
  logic             changed_q, changed_d, changed_nx;
  logic [VtxW-1:0]  s_q, s_d, t_q, t_d;
  logic [DistW-1:0] max_q, max_d, max_nx;
  run_stat_t        stat_q, stat_d;

  logic [CntW-1:0]  n;
  logic [DistW-1:0] n1, cand;
  logic             hit, in_range;

  logic             d_we, d_re_a, d_re_b;
  logic [AW-1:0]    d_waddr, d_raddr_a, d_raddr_b;
  logic [DistW-1:0] d_wdata, d_rdata_a, d_rdata_b;

  hef_ram #(
    .Width (DistW),
    .Depth (DistDepth)
  ) u_dist_ram (
    .clk_i     (clk_i),
    .we_i      (d_we),
    .waddr_i   (d_waddr),
    .wdata_i   (d_wdata),
    .re_a_i    (d_re_a),
    .raddr_a_i (d_raddr_a),
    .rdata_a_o (d_rdata_a),
    .re_b_i    (d_re_b),
    .raddr_b_i (d_raddr_b),
    .rdata_b_o (d_rdata_b)
  );

  assign n        = req_i.count;
  assign n1       = DistW'(n) + DistW'(1);
  assign v_nx     = v_q + CntW'(1);
  assign e_nx     = LW'(e_q) + LW'(1);
  assign pass_nx  = {1'b0, pass_q} + (CntW+1)'(1);
  assign cand     = d_rdata_a + DistW'(1);
  // edges naming a vertex beyond the current count are skipped
  assign in_range = ({1'b0, s_q} < n) && ({1'b0, t_q} < n);
  assign hit      = in_range && (cand < d_rdata_b);
  assign changed_nx = changed_q | hit;

  always_comb begin
    state_d      = state_q;
    v_d          = v_q;
    e_d          = e_q;
    pass_d       = pass_q;
    changed_d    = changed_q;
    s_d          = s_q;
    t_d          = t_q;
    max_d        = max_q;
    max_nx       = max_q;
    stat_d       = '0;
    d_we         = 1'b0;
    d_waddr      = '0;
    d_wdata      = '0;
    d_re_a       = 1'b0;
    d_raddr_a    = '0;
    d_re_b       = 1'b0;
    d_raddr_b    = '0;
    edge_re_o    = 1'b0;
    edge_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.go) begin
          if (n == '0) begin
            stat_d.done = 1'b1;
          end else if ({1'b0, req_i.start} >= n) begin
            stat_d.done = 1'b1;
            stat_d.bad  = 1'b1;
          end else begin
            v_d     = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        d_we    = 1'b1;
        d_waddr = AW'(v_q);
        d_wdata = (v_q == {1'b0, req_i.start}) ? '0 : n1;
        if (v_nx == n) begin
          v_d       = '0;
          e_d       = '0;
          pass_d    = '0;
          changed_d = 1'b0;
          max_d     = '0;
          state_d   = (edges_i == '0) ? S_SCAN : S_EREAD;
        end else begin
          v_d = v_nx;
        end
      end
      S_EREAD: begin
        edge_re_o    = 1'b1;
        edge_raddr_o = e_q;
        state_d      = S_EDGE;
      end
      S_EDGE: begin
        s_d       = edge_rdata_i[2*VtxW-1:VtxW];
        t_d       = edge_rdata_i[VtxW-1:0];
        d_re_a    = 1'b1;
        d_raddr_a = AW'(edge_rdata_i[2*VtxW-1:VtxW]);
        d_re_b    = 1'b1;
        d_raddr_b = AW'(edge_rdata_i[VtxW-1:0]);
        // fetch the next edge while its predecessor is relaxed
        if (e_nx < edges_i) begin
          edge_re_o    = 1'b1;
          edge_raddr_o = e_nx[EAW-1:0];
        end
        state_d = S_RELAX;
      end
      S_RELAX: begin
        if (hit) begin
          d_we    = 1'b1;
          d_waddr = AW'(t_q);
          d_wdata = cand;
        end
        if (e_nx < edges_i) begin
          e_d       = e_nx[EAW-1:0];
          changed_d = changed_nx;
          state_d   = S_EDGE;
        end else if (changed_nx && (pass_nx < {1'b0, n})) begin
          pass_d    = pass_nx[CntW-1:0];
          e_d       = '0;
          changed_d = 1'b0;
          state_d   = S_EREAD;
        end else begin
          v_d     = '0;
          max_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (v_q != n) begin
          d_re_a    = 1'b1;
          d_raddr_a = AW'(v_q);
          v_d       = v_nx;
        end
        // read data arrives in the cycle after its address
        if ((v_q != '0) && (d_rdata_a > max_q)) begin
          max_nx = d_rdata_a;
        end
        max_d = max_nx;
        if (v_q == n) begin
          stat_d.done    = 1'b1;
          stat_d.ecc     = max_nx[EccW-1:0];
          stat_d.unreach = (max_nx == n1);
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      v_q       <= '0;
      e_q       <= '0;
      pass_q    <= '0;
      changed_q <= 1'b0;
      stat_q    <= '0;
    end else begin
      state_q   <= state_d;
      v_q       <= v_d;
      e_q       <= e_d;
      pass_q    <= pass_d;
      changed_q <= changed_d;
      stat_q    <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    t_q   <= t_d;
    max_q <= max_d;
  end

  assign stat_o = stat_q;

endmodule

`default_nettype wire

### hw/rtl/hop_eccentricity_from_start.sv
// top level of the hop eccentricity block: edge loading, edge store, result
// depends on hef_pkg, hef_ram, hef_cfg_regs, hef_relax and the defines header
`default_nettype none

`include "hop_eccentricity_from_start_defines.svh"

// Usage
// Program vertex_count (0x0) and start_vertex (0x4) over the apb port while
// the block is idle. Then send items with start while busy is low; one item
// is taken per cycle. An item with edge_valid stores its edge, or drops it if
// the store is full or a vertex is not below the count. An item with
// last_edge closes the graph and raises busy for the run.
// A run with zero vertices or a bad start vertex reports from the idle state.
// Otherwise, for N vertices and E stored edges, it seeds the distance ram
// vertex by vertex, makes at most N passes over the edges (per edge, an edge
// ram read, then the distance read-modify-write), and ends with a scan of
// every vertex for the final maximum.
// The result shows on result_o for one cycle with result_valid_o; the
// receiver cannot stall it. Busy drops in the same cycle as the result
// strobe, so loading of the next graph may overlap the result transfer.
// Reset clears the configuration and control registers, the edge count and
// the drop flag; the memories are not cleared and need no clearing pass.
module hop_eccentricity_from_start #(
  parameter int MAX_VERTICES = hef_pkg::MaxVertices,
  parameter int MAX_EDGES    = hef_pkg::MaxEdges
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire hef_pkg::item_t   item_i,
  output logic                  result_valid_o,
  output hef_pkg::result_t      result_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);
  import hef_pkg::*;

  localparam int EAW    = $clog2(MAX_EDGES > 1 ? MAX_EDGES : 2);
  localparam int LW     = $clog2(MAX_EDGES + 1);
  localparam int CapCnt = (MAX_VERTICES < 511) ? MAX_VERTICES : 511;

  logic [CntW-1:0] vertex_count, n;
  logic [VtxW-1:0] start_vertex;

  logic            accept, drop_now, store_now;
  logic [LW-1:0]   loaded_q, loaded_d;
  logic [LW-1:0]   edges_run_q;
  logic            drop_q, drop_d, drop_run_q;
  logic            busy_q, go_q;
  logic            result_valid_q;
  result_t         result_q;

  run_req_t        req;
  run_stat_t       stat;
  logic            edge_re;
  logic [EAW-1:0]  edge_raddr;
  logic [2*VtxW-1:0] edge_rdata;

  hef_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready),
    .vertex_count_o (vertex_count),
    .start_vertex_o (start_vertex)
  );

  assign n = (vertex_count > CntW'(CapCnt)) ? CntW'(CapCnt) : vertex_count;

  // edge loading
  assign accept    = start & ~busy_q;
  assign drop_now  = item_i.edge_valid &
                     ((loaded_q == LW'(MAX_EDGES)) ||
                      ({1'b0, item_i.edge_source} >= n) ||
                      ({1'b0, item_i.edge_target} >= n));
  assign store_now = accept & item_i.edge_valid & ~drop_now;

  always_comb begin
    loaded_d = loaded_q;
    drop_d   = drop_q;
    if (accept) begin
      if (item_i.last_edge) begin
        loaded_d = '0;
        drop_d   = 1'b0;
      end else begin
        loaded_d = store_now ? loaded_q + LW'(1) : loaded_q;
        drop_d   = drop_q | drop_now;
      end
    end
  end

  hef_ram #(
    .Width (2*VtxW),
    .Depth (MAX_EDGES)
  ) u_edge_ram (
    .clk_i     (clk_i),
    .we_i      (store_now),
    .waddr_i   (loaded_q[EAW-1:0]),
    .wdata_i   ({item_i.edge_source, item_i.edge_target}),
    .re_a_i    (edge_re),
    .raddr_a_i (edge_raddr),
    .rdata_a_o (edge_rdata),
    .re_b_i    (1'b0),
    .raddr_b_i ('0),
    .rdata_b_o ()
  );

  assign req.go    = go_q;
  assign req.count = n;
  assign req.start = start_vertex;

  hef_relax #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_relax (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .edges_i      (edges_run_q),
    .edge_re_o    (edge_re),
    .edge_raddr_o (edge_raddr),
    .edge_rdata_i (edge_rdata),
    .stat_o       (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q       <= '0;
      drop_q         <= 1'b0;
      busy_q         <= 1'b0;
      go_q           <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      loaded_q       <= loaded_d;
      drop_q         <= drop_d;
      go_q           <= accept & item_i.last_edge;
      result_valid_q <= stat.done;
      if (accept && item_i.last_edge) begin
        busy_q <= 1'b1;
      end else if (stat.done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && item_i.last_edge) begin
      edges_run_q <= store_now ? loaded_q + LW'(1) : loaded_q;
      drop_run_q  <= drop_q | drop_now;
    end
    if (stat.done) begin
      result_q.eccentricity  <= stat.ecc;
      result_q.unreachable   <= stat.unreach;
      result_q.bad_start     <= stat.bad;
      result_q.edges_dropped <= drop_run_q;
    end
  end

  assign busy           = busy_q;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `HEF_ASSERT_NOW(a_done_in_run, stat.done, busy_q, "run finished while not busy")
  `HEF_ASSERT_NEXT(a_single_result, result_valid_o, !result_valid_o, "result strobe held twice")
  `HEF_ASSERT_NOW(a_load_cap, 1'b1, loaded_q <= LW'(MAX_EDGES), "edge count beyond capacity")
  `HEF_ASSERT_NOW(a_bad_clean, result_valid_o && result_o.bad_start,
                  !result_o.unreachable && (result_o.eccentricity == '0),
                  "bad start with distance result")

endmodule

`default_nettype wire

### test/hop_eccentricity_from_start_checker.sv
// scoreboard for the hop eccentricity block: register addresses, a predictor of
// each graph run and field-by-field comparison of every result transfer
// depends on hef_pkg
`default_nettype none

package hef_tb_pkg;

  localparam logic [2:0] AddrVertexCount = 3'h0;
  localparam logic [2:0] AddrStartVertex = 3'h4;

endpackage

module hop_eccentricity_from_start_checker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             busy_i,
  input  wire hef_pkg::item_t   item_i,
  input  wire logic             result_valid_i,
  input  wire hef_pkg::result_t result_i,
  input  wire logic             psel_i,
  input  wire logic             penable_i,
  input  wire logic             pwrite_i,
  input  wire logic             pready_i,
  input  wire logic [2:0]       paddr_i,
  input  wire logic [31:0]      pwdata_i,
  output int                    pending_o,
  output int                    errors_o
);
  import hef_pkg::*;
  import hef_tb_pkg::*;

  logic [CntW-1:0] vtx_count;
  logic [VtxW-1:0] start_vtx;
  logic [VtxW-1:0] src_store [MaxEdges];
  logic [VtxW-1:0] dst_store [MaxEdges];
  int              edges_held;
  logic            edge_lost;
  int              hop_dist [MaxVertices];
  result_t         exp_fifo [8];
  logic [2:0]      exp_wr;
  logic [2:0]      exp_rd;
  int              exp_cnt;
  int              mismatches = 0;

  assign errors_o = mismatches;

  function automatic int vertices_in_use();
    return (vtx_count > MaxVertices) ? MaxVertices : int'(vtx_count);
  endfunction

  // runs the relaxation passes over the stored edges and clears the graph
  function automatic result_t eccentricity_of_graph();
    result_t r;
    int      n;
    int      v;
    int      p;
    int      e;
    int      s;
    int      t;
    int      worst;
    logic    changed;
    r = '0;
    n = vertices_in_use();
    if (n != 0 && int'(start_vtx) >= n) begin
      r.bad_start = 1'b1;
    end else if (n != 0) begin
      for (v = 0; v < n; v++) hop_dist[v] = n + 1;
      hop_dist[start_vtx] = 0;
      for (p = 0; p < n; p++) begin
        changed = 1'b0;
        for (e = 0; e < edges_held; e++) begin
          s = int'(src_store[e]);
          t = int'(dst_store[e]);
          // edges stored under a larger count are skipped silently
          if (s < n && t < n && hop_dist[s] + 1 < hop_dist[t]) begin
            hop_dist[t] = hop_dist[s] + 1;
            changed = 1'b1;
          end
        end
        if (!changed) break;
      end
      worst = 0;
      for (v = 0; v < n; v++) if (hop_dist[v] > worst) worst = hop_dist[v];
      r.eccentricity = worst[EccW-1:0];
      r.unreachable  = (worst == n + 1);
    end
    r.edges_dropped = edge_lost;
    edges_held = 0;
    edge_lost  = 1'b0;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    int      n;
    if (!rst_ni) begin
      vtx_count  = '0;
      start_vtx  = '0;
      edges_held = 0;
      edge_lost  = 1'b0;
      exp_wr     = '0;
      exp_rd     = '0;
      exp_cnt    = 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          AddrVertexCount: vtx_count = pwdata_i[CntW-1:0];
          AddrStartVertex: start_vtx = pwdata_i[VtxW-1:0];
          default: ;
        endcase
      end
      if (result_valid_i) begin
        if (exp_cnt == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result_i);
          mismatches++;
        end else begin
          want    = exp_fifo[exp_rd];
          exp_rd  = exp_rd + 3'd1;
          exp_cnt = exp_cnt - 1;
          check_field("eccentricity", int'(want.eccentricity),
                      int'(result_i.eccentricity));
          check_field("unreachable", int'(want.unreachable), int'(result_i.unreachable));
          check_field("bad_start", int'(want.bad_start), int'(result_i.bad_start));
          check_field("edges_dropped", int'(want.edges_dropped),
                      int'(result_i.edges_dropped));
        end
      end
      if (start_i && !busy_i) begin
        if (item_i.edge_valid) begin
          n = vertices_in_use();
          if (edges_held >= MaxEdges || int'(item_i.edge_source) >= n ||
              int'(item_i.edge_target) >= n) begin
            edge_lost = 1'b1;
          end else begin
            src_store[edges_held] = item_i.edge_source;
            dst_store[edges_held] = item_i.edge_target;
            edges_held++;
          end
        end
        if (item_i.last_edge) begin
          exp_fifo[exp_wr] = eccentricity_of_graph();
          exp_wr  = exp_wr + 3'd1;
          exp_cnt = exp_cnt + 1;
        end
      end
      pending_o <= exp_cnt;
    end
  end

endmodule

`default_nettype wire

### test/hop_eccentricity_from_start_tb.sv
// top of the hop eccentricity testbench: clock, reset, register writes and
// edge stimulus; depends on hef_pkg, the block and its checker
`default_nettype none

module hop_eccentricity_from_start_tb;
  import hef_pkg::*;
  import hef_tb_pkg::*;

  localparam int ItemTarget = 1750;
  localparam int QuietFrom  = 1600;
  localparam int CycleLimit = 1_000_000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  item_t       edge_item = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        result_valid;
  result_t     result;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          errors;
  int          cycle_count = 0;
  int          sent = 0;
  int          cur_eff = 0;
  logic        idle_on = 1'b0;

  always #4 clk_i = ~clk_i;

  hop_eccentricity_from_start uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (edge_item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  hop_eccentricity_from_start_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (edge_item),
    .result_valid_i (result_valid),
    .result_i       (result),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[hop_eccentricity_from_start] ERROR");
      $finish;
    end
  end

  function automatic item_t mk(input logic v, input logic [7:0] s, input logic [7:0] d,
                               input logic l);
    item_t it;
    it.edge_valid  = v;
    it.edge_source = s;
    it.edge_target = d;
    it.last_edge   = l;
    return it;
  endfunction

  // mostly edges between present vertices, some noise
  function automatic item_t pick_edge(input int eff, input logic l);
    item_t it;
    it = mk(1'b1, 8'($urandom()), 8'($urandom()), l);
    case ($urandom_range(0, 11))
      0: it.edge_valid = 1'b0;
      1: ;
      default: begin
        if (eff > 0) begin
          it.edge_source = 8'($urandom_range(0, eff - 1));
          it.edge_target = 8'($urandom_range(0, eff - 1));
        end
      end
    endcase
    return it;
  endfunction

  task automatic send(input item_t it);
    start     <= 1'b1;
    edge_item <= it;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic maybe_idle();
    if (idle_on && sent < QuietFrom && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // wait for every result, then let the edge store write settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input int value, input int width);
    logic [31:0] word;
    word = value;
    // the block keeps only the low bits
    if ($urandom_range(0, 1)) word = ($urandom() << width) | value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_count(input int cnt);
    write_reg(AddrVertexCount, cnt, CntW);
    cur_eff = (cnt > MaxVertices) ? MaxVertices : cnt;
  endtask

  task automatic configure(input int cnt, input int sv);
    drain();
    set_count(cnt);
    write_reg(AddrStartVertex, sv, VtxW);
  endtask

  // path through every vertex, edges loaded forwards or backwards
  task automatic chain(input int cnt, input logic backwards);
    int i;
    configure(cnt, 0);
    for (i = 0; i < cnt - 1; i++) begin
      maybe_idle();
      if (backwards) send(mk(1'b1, 8'(cnt - 2 - i), 8'(cnt - 1 - i), 1'b0));
      else send(mk(1'b1, 8'(i), 8'(i + 1), 1'b0));
    end
    send(mk(1'b0, 8'($urandom()), 8'($urandom()), 1'b1));
  endtask

  initial begin
    int c;
    int sv;
    int n_edges;
    int graphs;
    graphs = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty graph at reset values: an edge into it is dropped
    send(mk(1'b1, 8'h00, 8'h00, 1'b0));
    send(mk(1'b0, 8'hff, 8'hff, 1'b1));
    send(mk(1'b0, 8'h00, 8'h00, 1'b1));
    // start out of range is ignored when there are no vertices
    configure(0, 255);
    send(mk(1'b0, 8'h00, 8'h00, 1'b1));
    configure(4, 0);
    send(mk(1'b1, 8'd0, 8'd1, 1'b0));
    send(mk(1'b1, 8'd1, 8'd2, 1'b0));
    send(mk(1'b1, 8'd2, 8'd3, 1'b0));
    send(mk(1'b1, 8'd3, 8'd0, 1'b1));
    // same path loaded backwards needs one pass per hop
    send(mk(1'b1, 8'd2, 8'd3, 1'b0));
    send(mk(1'b1, 8'd1, 8'd2, 1'b0));
    send(mk(1'b1, 8'd0, 8'd1, 1'b1));
    configure(4, 4);
    send(mk(1'b1, 8'd0, 8'd1, 1'b1));
    // absent vertices are dropped and flagged
    configure(4, 0);
    send(mk(1'b1, 8'd0, 8'd4, 1'b0));
    send(mk(1'b1, 8'd5, 8'd1, 1'b0));
    send(mk(1'b1, 8'hff, 8'hff, 1'b0));
    send(mk(1'b1, 8'd3, 8'd3, 1'b1));
    configure(256, 255);
    send(mk(1'b1, 8'hff, 8'h00, 1'b0));
    send(mk(1'b0, 8'h00, 8'h00, 1'b1));
    configure(511, 0);
    send(mk(1'b1, 8'h00, 8'hff, 1'b1));
    // count lowered after loading: the stored edge to vertex 7 is skipped
    configure(8, 0);
    send(mk(1'b1, 8'd0, 8'd1, 1'b0));
    send(mk(1'b1, 8'd1, 8'd7, 1'b0));
    drain();
    set_count(4);
    send(mk(1'b0, 8'h00, 8'h00, 1'b1));

    // fill the edge store past its capacity
    idle_on = 1'b1;
    configure(4, $urandom_range(0, 3));
    repeat (MaxEdges + 16) begin
      maybe_idle();
      send(mk(1'b1, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 1'b0));
    end
    send(pick_edge(4, 1'b1));

    chain(256, 1'b0);
    chain(48, 1'b1);

    while (sent < ItemTarget || graphs < 40) begin
      idle_on = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 19))
          0: c = 0;
          1: c = $urandom_range(257, 511);
          2, 3: c = $urandom_range(13, 256);
          default: c = $urandom_range(1, 12);
        endcase
        if (c == 0 || $urandom_range(0, 9) == 0) sv = $urandom_range(0, 255);
        else sv = $urandom_range(0, ((c > MaxVertices) ? MaxVertices : c) - 1);
        configure(c, sv);
      end
      n_edges = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      repeat (n_edges) begin
        maybe_idle();
        send(pick_edge(cur_eff, 1'b0));
      end
      if ($urandom_range(0, 9) == 0) begin
        drain();
        set_count($urandom_range(0, 20));
      end
      maybe_idle();
      send(pick_edge(cur_eff, 1'b1));
      graphs++;
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[hop_eccentricity_from_start] OK");
    end else begin
      $display("[hop_eccentricity_from_start] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
